// ===== rtl/chtbl_pkg.sv =====
// chtbl_pkg: shared constants and controller/datapath interface types
`default_nettype none

package chtbl_pkg;

    localparam int HASH_BYTES_DEFAULT   = 1;
    localparam int POOL_ENTRIES_DEFAULT = 256;
    localparam int COUNT_W              = 9;
    localparam int KEY_W                = 64;
    localparam int VALUE_W              = 64;

    localparam logic ACTION_PUT = 1'b0;
    localparam logic ACTION_GET = 1'b1;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic cur_from_head;
        logic hit;
        logic step;
        logic upd_wr;
        logic alloc_rd;
        logic pop_free;
        logic take_nun;
        logic drop;
        logic wr_new;
        logic link_wr;
        logic free_wr;
        logic result;
    } chtbl_cmd_t;

    typedef struct packed {
        logic head_nil;
        logic key_eq;
        logic link_nil;
        logic is_get;
        logic val_zero;
        logic found;
        logic free_valid;
        logic nun_avail;
        logic clr_last;
        logic out_busy;
    } chtbl_status_t;

endpackage

`default_nettype wire

// ===== rtl/chtbl_ram.sv =====
// chtbl_ram: generic single-write, single-read memory with registered read data
`default_nettype none

module chtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/chtbl_dp.sv =====
// chtbl_dp: table memories, allocation registers, chain walk registers and result register
`default_nettype none

module chtbl_dp #(
    parameter int HASH_BYTES   = chtbl_pkg::HASH_BYTES_DEFAULT,
    parameter int POOL_ENTRIES = chtbl_pkg::POOL_ENTRIES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire chtbl_pkg::chtbl_cmd_t            cmd,
    output chtbl_pkg::chtbl_status_t              sts,
    input  wire logic                             action,
    input  wire logic [chtbl_pkg::KEY_W-1:0]      key,
    input  wire logic [chtbl_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  found,
    output logic      [chtbl_pkg::VALUE_W-1:0]    value_out,
    output logic                                  status,
    output logic      [chtbl_pkg::COUNT_W-1:0]    count
);

    localparam int IW = $clog2(POOL_ENTRIES + 1);
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int BW = (HASH_BYTES == 2) ? 16 : 8;
    localparam int BUCKETS = 1 << BW;
    localparam logic [IW-1:0] NIL = IW'(POOL_ENTRIES);
    localparam int KW = chtbl_pkg::KEY_W;
    localparam int VW = chtbl_pkg::VALUE_W;

    function automatic logic [BW-1:0] bucket_of(input logic [KW-1:0] k);
        logic [7:0] h;
        h = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            h = h ^ k[8*i +: 8];
        end
        if (HASH_BYTES == 2)
        begin
            return BW'({k[7:0], h});
        end
        return BW'(h);
    endfunction

    // item registers
    logic            action_reg;
    logic [KW-1:0]   key_reg;
    logic [VW-1:0]   value_reg;
    logic [BW-1:0]   bkt_reg;
    logic [IW-1:0]   cur_reg;
    logic [IW-1:0]   prev_reg;
    logic [IW-1:0]   link_cur_reg;
    logic [VW-1:0]   val_cur_reg;
    logic [IW-1:0]   e_reg;
    logic            found_reg;
    logic            drop_reg;

    // table control state
    logic [IW-1:0]   free_head_reg, free_head_next;
    logic [IW-1:0]   nun_reg, nun_next;
    logic [IW-1:0]   held_reg, held_next;
    logic [BW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            out_valid_reg, out_valid_next;

    // result register
    logic            found_out_reg;
    logic [VW-1:0]   value_out_reg;
    logic            status_out_reg;
    logic [chtbl_pkg::COUNT_W-1:0] count_out_reg;

    // memory ports
    logic            head_we;
    logic [BW-1:0]   head_waddr;
    logic [IW-1:0]   head_wdata;
    logic [IW-1:0]   head_rdata;
    logic [AW-1:0]   ent_raddr;
    logic [IW-1:0]   ent_ridx;
    logic [KW-1:0]   key_rdata;
    logic [VW-1:0]   val_rdata;
    logic [IW-1:0]   link_rdata;
    logic            kv_we;
    logic            val_we;
    logic [VW-1:0]   val_wdata;
    logic [AW-1:0]   val_waddr;
    logic            link_we;
    logic [IW-1:0]   link_widx;
    logic [IW-1:0]   link_wdata;
    logic [IW-1:0]   link_val;

    assign link_val = found_reg ? link_cur_reg : e_reg;

    always_comb
    begin
        if (cmd.cur_from_head)
        begin
            ent_ridx = head_rdata;
        end
        else if (cmd.step)
        begin
            ent_ridx = link_rdata;
        end
        else if (cmd.alloc_rd)
        begin
            ent_ridx = free_head_reg;
        end
        else
        begin
            ent_ridx = cur_reg;
        end
    end

    assign ent_raddr = ent_ridx[AW-1:0];

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = bkt_reg;
        head_wdata = link_val;
        if (cmd.clr_wr)
        begin
            head_we    = 1'b1;
            head_waddr = clr_cnt_reg;
            head_wdata = NIL;
        end
        else if (cmd.link_wr && (prev_reg == NIL))
        begin
            head_we = 1'b1;
        end
    end

    always_comb
    begin
        link_we    = 1'b0;
        link_widx  = prev_reg;
        link_wdata = link_val;
        if (cmd.wr_new)
        begin
            link_we    = 1'b1;
            link_widx  = e_reg;
            link_wdata = NIL;
        end
        else if (cmd.link_wr && (prev_reg != NIL))
        begin
            link_we = 1'b1;
        end
        else if (cmd.free_wr)
        begin
            link_we    = 1'b1;
            link_widx  = cur_reg;
            link_wdata = free_head_reg;
        end
    end

    assign kv_we     = cmd.wr_new;
    assign val_we    = cmd.wr_new || cmd.upd_wr;
    assign val_waddr = cmd.upd_wr ? cur_reg[AW-1:0] : e_reg[AW-1:0];
    assign val_wdata = value_reg;

    chtbl_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_heads (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bkt_reg),
        .rdata (head_rdata)
    );

    chtbl_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk   (clk),
        .we    (kv_we),
        .waddr (e_reg[AW-1:0]),
        .wdata (key_reg),
        .raddr (ent_raddr),
        .rdata (key_rdata)
    );

    chtbl_ram #(.WIDTH(VW), .DEPTH(POOL_ENTRIES)) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (ent_raddr),
        .rdata (val_rdata)
    );

    chtbl_ram #(.WIDTH(IW), .DEPTH(POOL_ENTRIES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_widx[AW-1:0]),
        .wdata (link_wdata),
        .raddr (ent_raddr),
        .rdata (link_rdata)
    );

    // control state next values
    always_comb
    begin
        free_head_next = free_head_reg;
        nun_next       = nun_reg;
        held_next      = held_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.clr_wr)
        begin
            clr_cnt_next = clr_cnt_reg + BW'(1);
        end
        if (cmd.pop_free)
        begin
            free_head_next = link_rdata;
        end
        if (cmd.take_nun)
        begin
            nun_next = nun_reg + IW'(1);
        end
        if (cmd.wr_new)
        begin
            held_next = held_reg + IW'(1);
        end
        if (cmd.free_wr)
        begin
            free_head_next = cur_reg;
            if (held_reg != '0)
            begin
                held_next = held_reg - IW'(1);
            end
        end
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= NIL;
            nun_reg       <= '0;
            held_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            nun_reg       <= nun_next;
            held_reg      <= held_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
            bkt_reg    <= bucket_of(key);
            prev_reg   <= NIL;
            cur_reg    <= NIL;
            found_reg  <= 1'b0;
            drop_reg   <= 1'b0;
        end
        if (cmd.cur_from_head)
        begin
            cur_reg <= head_rdata;
        end
        if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= link_rdata;
        end
        if (cmd.hit)
        begin
            found_reg    <= 1'b1;
            link_cur_reg <= link_rdata;
            val_cur_reg  <= val_rdata;
        end
        if (cmd.alloc_rd)
        begin
            e_reg <= free_head_reg;
        end
        if (cmd.take_nun)
        begin
            e_reg <= nun_reg;
        end
        if (cmd.drop)
        begin
            drop_reg <= 1'b1;
        end
        if (cmd.result)
        begin
            found_out_reg  <= found_reg;
            value_out_reg  <= (action_reg == chtbl_pkg::ACTION_GET && found_reg) ?
                              val_cur_reg : '0;
            status_out_reg <= drop_reg ? chtbl_pkg::STATUS_DROPPED : chtbl_pkg::STATUS_DONE;
            count_out_reg  <= chtbl_pkg::COUNT_W'(held_reg);
        end
    end

    assign sts.head_nil   = (head_rdata == NIL);
    assign sts.key_eq     = (key_rdata == key_reg);
    assign sts.link_nil   = (link_rdata == NIL);
    assign sts.is_get     = (action_reg == chtbl_pkg::ACTION_GET);
    assign sts.val_zero   = (value_reg == '0);
    assign sts.found      = found_reg;
    assign sts.free_valid = (free_head_reg != NIL);
    assign sts.nun_avail  = (nun_reg != NIL);
    assign sts.clr_last   = (clr_cnt_reg == '1);
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign found     = found_out_reg;
    assign value_out = value_out_reg;
    assign status    = status_out_reg;
    assign count     = count_out_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= NIL)
        else $error("entry count above pool size");

    a_nun_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nun_reg <= NIL)
        else $error("never-used pointer past pool end");

    a_alloc_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_new |-> (e_reg != NIL))
        else $error("new entry written at null index");

    a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

endmodule

`default_nettype wire

// ===== rtl/chtbl_ctrl.sv =====
// chtbl_ctrl: sequencer for clearing, chain walk and table update
`default_nettype none

module chtbl_ctrl (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire chtbl_pkg::chtbl_status_t sts,
    output chtbl_pkg::chtbl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_HEADW,
        S_CMP,
        S_ACT,
        S_ALLOC,
        S_WRNEW,
        S_LINK,
        S_FREE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                cmd.cur_from_head = 1'b1;
                state_next = sts.head_nil ? S_ACT : S_CMP;
            end
            S_CMP:
            begin
                if (sts.key_eq)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_ACT;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.link_nil)
                    begin
                        state_next = S_ACT;
                    end
                end
            end
            S_ACT:
            begin
                if (sts.is_get)
                begin
                    state_next = S_DONE;
                end
                else if (sts.found)
                begin
                    if (sts.val_zero)
                    begin
                        state_next = S_LINK;
                    end
                    else
                    begin
                        cmd.upd_wr = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if (sts.val_zero)
                begin
                    state_next = S_DONE;
                end
                else if (sts.free_valid)
                begin
                    cmd.alloc_rd = 1'b1;
                    state_next   = S_ALLOC;
                end
                else if (sts.nun_avail)
                begin
                    cmd.take_nun = 1'b1;
                    state_next   = S_WRNEW;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_ALLOC:
            begin
                cmd.pop_free = 1'b1;
                state_next   = S_WRNEW;
            end
            S_WRNEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.link_wr = 1'b1;
                state_next  = sts.found ? S_FREE : S_DONE;
            end
            S_FREE:
            begin
                cmd.free_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_link_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.wr_new, cmd.link_wr, cmd.free_wr, cmd.clr_wr}))
        else $error("two writes to the link or head memory in one cycle");

    a_free_after_link: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_wr |-> $past(cmd.link_wr))
        else $error("entry freed without being unlinked");

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table.sv =====
// chained_hash_table: key/value table with chained buckets, top level
//
// Input channel (in_valid/in_ready) takes one transaction per item: action
// (0 = put, 1 = get), a 64-bit key and a 64-bit value. A put with nonzero value
// inserts or overwrites, a put with zero value removes. Every item gives exactly
// one result transaction on the output channel (out_valid/out_ready): found,
// value_out, status (1 = insert dropped, pool full) and count of held entries.
// Items are processed one at a time. Each item is loaded, its bucket head is read,
// then the bucket chain is walked, one entry memory read per cycle, then update
// work follows (insert from the free list is the longest) and the result is
// written to the output register.
// After reset the bucket head memory is cleared one row per cycle, all 256 rows
// (65536 with two-byte hashing), during which in_ready stays low.
// The result sits in an output register; while the receiver stalls, the next
// item is accepted and walked, and it waits only for the register to empty.
`default_nettype none

module chained_hash_table #(
    parameter int HASH_BYTES   = chtbl_pkg::HASH_BYTES_DEFAULT,
    parameter int POOL_ENTRIES = chtbl_pkg::POOL_ENTRIES_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             action,
    input  wire logic [chtbl_pkg::KEY_W-1:0]      key,
    input  wire logic [chtbl_pkg::VALUE_W-1:0]    value,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  found,
    output logic      [chtbl_pkg::VALUE_W-1:0]    value_out,
    output logic                                  status,
    output logic      [chtbl_pkg::COUNT_W-1:0]    count
);

    chtbl_pkg::chtbl_cmd_t    cmd;
    chtbl_pkg::chtbl_status_t sts;

    chtbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    chtbl_dp #(
        .HASH_BYTES   (HASH_BYTES),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (action),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .value_out (value_out),
        .status    (status),
        .count     (count)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for chained_hash_table with a behavioral table model
`default_nettype none

module tb;

    localparam int POOL = chtbl_pkg::POOL_ENTRIES_DEFAULT;
    localparam int NIL = POOL;
    localparam int LIMIT_CYCLES = 400000;
    localparam int KW = chtbl_pkg::KEY_W;
    localparam int VW = chtbl_pkg::VALUE_W;
    localparam int CW = chtbl_pkg::COUNT_W;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
    logic out_valid;
    logic out_ready;
    logic found;
    logic [VW-1:0] value_out;
    logic status;
    logic [CW-1:0] count;

    chained_hash_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .key(key), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .value_out(value_out), .status(status), .count(count)
    );

    typedef struct packed {
        logic found;
        logic [VW-1:0] value_out;
        logic status;
        logic [CW-1:0] count;
    } lookup_result_t;

    // table model state
    int unsigned chain_head[256];
    logic [KW-1:0] slot_key[POOL];
    logic [VW-1:0] slot_val[POOL];
    int unsigned slot_next[POOL];
    int unsigned free_list;
    int unsigned fresh_slot;
    int unsigned held;

    lookup_result_t pending_results[$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet_in;
    bit quiet_out;
    bit hold_out;
    logic [KW-1:0] key_pool[$];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned fold_key(logic [KW-1:0] k);
        logic [7:0] h;
        h = 8'h00;
        for (int i = 0; i < 8; i++)
            h ^= k[8*i +: 8];
        return 32'(h);
    endfunction

    function automatic lookup_result_t table_apply(logic act, logic [KW-1:0] k,
                                                   logic [VW-1:0] v);
        lookup_result_t r;
        int unsigned b;
        int unsigned prev;
        int unsigned cur;
        int unsigned e;
        r = '0;
        b = fold_key(k);
        prev = NIL;
        cur = chain_head[b];
        while (cur != NIL && slot_key[cur] != k) begin
            prev = cur;
            cur = slot_next[cur];
        end
        r.found = (cur != NIL);
        if (act == chtbl_pkg::ACTION_GET) begin
            if (cur != NIL)
                r.value_out = slot_val[cur];
        end
        else if (cur != NIL) begin
            if (v == '0) begin
                if (prev != NIL)
                    slot_next[prev] = slot_next[cur];
                else
                    chain_head[b] = slot_next[cur];
                slot_next[cur] = free_list;
                free_list = cur;
                if (held > 0)
                    held--;
            end
            else
                slot_val[cur] = v;
        end
        else if (v != '0) begin
            e = NIL;
            if (free_list != NIL) begin
                e = free_list;
                free_list = slot_next[e];
            end
            else if (fresh_slot < POOL) begin
                e = fresh_slot;
                fresh_slot++;
            end
            if (e != NIL) begin
                slot_key[e] = k;
                slot_val[e] = v;
                slot_next[e] = NIL;
                if (prev != NIL)
                    slot_next[prev] = e;
                else
                    chain_head[b] = e;
                held++;
            end
            else
                r.status = chtbl_pkg::STATUS_DROPPED;
        end
        r.count = held[CW-1:0];
        return r;
    endfunction

    // valid stays high between back-to-back transactions, drops only when idling
    task automatic send_item(logic act, logic [KW-1:0] k, logic [VW-1:0] v);
        while (!quiet_in && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(table_apply(act, k, v));
    endtask

    // receiver side: random stalls plus a forced long hold-off
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_out && (quiet_out || $urandom_range(99) >= 7);
    end

    always @(posedge clk) begin
        lookup_result_t exp_r;
        lookup_result_t got;
        if (rst_n && out_valid && out_ready) begin
            got = '{found, value_out, status, count};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %p", got);
            end
            else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected found=%0d value=%h status=%0d ",
                                  "count=%0d, got found=%0d value=%h status=%0d count=%0d"},
                                 exp_r.found, exp_r.value_out, exp_r.status, exp_r.count,
                                 got.found, got.value_out, got.status, got.count);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL chained_hash_table");
            $finish;
        end
    end

    function automatic logic [KW-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [VW-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [KW-1:0] k1;
        logic [KW-1:0] k2;
        logic [KW-1:0] k3;
        // three keys that share bucket 0
        k1 = 64'h0;
        k2 = 64'h0101_0000_0000_0000;
        k3 = 64'hFFFF_FFFF_FFFF_FFFF;
        send_item(chtbl_pkg::ACTION_GET, k1, '1);
        send_item(chtbl_pkg::ACTION_PUT, k1, '0);
        send_item(chtbl_pkg::ACTION_PUT, k1, 64'h1);
        send_item(chtbl_pkg::ACTION_PUT, k2, '1);
        send_item(chtbl_pkg::ACTION_PUT, k3, 64'h8000_0000_0000_0000);
        send_item(chtbl_pkg::ACTION_GET, k3, '0);
        send_item(chtbl_pkg::ACTION_PUT, k2, 64'h5555_AAAA_5555_AAAA);
        send_item(chtbl_pkg::ACTION_GET, k2, '0);
        send_item(chtbl_pkg::ACTION_PUT, k2, '0);
        send_item(chtbl_pkg::ACTION_GET, k2, '0);
        send_item(chtbl_pkg::ACTION_GET, k3, '0);
        send_item(chtbl_pkg::ACTION_PUT, k1, '0);
        send_item(chtbl_pkg::ACTION_GET, k3, '0);
        send_item(chtbl_pkg::ACTION_PUT, k2, 64'h77);
        send_item(chtbl_pkg::ACTION_PUT, k3, '0);
        send_item(chtbl_pkg::ACTION_PUT, k2, '0);
        send_item(chtbl_pkg::ACTION_GET, 64'h1234_5678_9ABC_DEF0, '0);
    endtask

    task automatic test_random_mix(int n);
        logic [KW-1:0] k;
        int sel;
        for (int i = 0; i < n; i++) begin
            if (key_pool.size() == 0 || $urandom_range(3) == 0) begin
                k = rand_key();
                key_pool.push_back(k);
            end
            else
                k = key_pool[$urandom_range(key_pool.size() - 1)];
            sel = $urandom_range(9);
            if (sel < 4)
                send_item(chtbl_pkg::ACTION_PUT, k, rand_value());
            else if (sel < 6)
                send_item(chtbl_pkg::ACTION_PUT, k, '0);
            else
                send_item(chtbl_pkg::ACTION_GET, k, rand_value());
        end
    endtask

    // fill the pool to overflow, probe missing keys, remove up to 64 entries, then insert 32 new keys
    task automatic test_pool_full();
        logic [KW-1:0] k;
        for (int i = 0; i < POOL + 8; i++) begin
            k = {$urandom, 24'h0, i[7:0]} ^ {56'h0, i[15:8]};
            k[63:56] = 8'(i >> 8) ^ 8'h5A;
            send_item(chtbl_pkg::ACTION_PUT, k, rand_value() | 64'h1);
        end
        for (int i = 0; i < 40; i++)
            send_item(chtbl_pkg::ACTION_GET, rand_key(), '0);
        for (int i = 0; i < 64; i++)
            send_item(chtbl_pkg::ACTION_PUT, slot_key[$urandom_range(POOL - 1)], '0);
        for (int i = 0; i < 32; i++)
            send_item(chtbl_pkg::ACTION_PUT, rand_key(), rand_value() | 64'h2);
    endtask

    task automatic test_backpressure();
        int hold_cycles;
        hold_cycles = 0;
        hold_out = 1'b1;
        fork
            test_random_mix(12);
            begin
                while (hold_cycles < 300) begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_out = 1'b0;
            end
        join
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = chtbl_pkg::ACTION_PUT;
        key = '0;
        value = '0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        hold_out = 1'b0;
        for (int i = 0; i < 256; i++)
            chain_head[i] = NIL;
        for (int i = 0; i < POOL; i++) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_next[i] = NIL;
        end
        free_list = NIL;
        fresh_slot = 0;
        held = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(150);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        test_random_mix(60);
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        test_backpressure();
        test_pool_full();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("PASS chained_hash_table");
        else
            $display("FAIL chained_hash_table");
        $finish;
    end
endmodule

`default_nettype wire

// ===== chained_hash_table.f =====
rtl/chtbl_pkg.sv
rtl/chtbl_ram.sv
rtl/chtbl_dp.sv
rtl/chtbl_ctrl.sv
rtl/chained_hash_table.sv
tb/tb.sv
